[rtl/core/srxf_pkg.sv]
// Shared types and constants of the serial receive filter with ring buffer.
package srxf_pkg;

   // Ring buffer geometry
   localparam int BUF_DEPTH = 128;
   localparam int PTR_W     = $clog2(BUF_DEPTH);

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int FUNC_W  = 2;
   localparam int EVENT_W = 3;
   localparam int FILL_W  = 8;
   localparam int CSR_IDX_W = 3;

   // Fixed reset character
   localparam logic [BYTE_W-1:0] AMP_CHAR = 8'h26;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_RX    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

   // Event codes
   localparam logic [EVENT_W-1:0] EV_NONE   = 3'd0;
   localparam logic [EVENT_W-1:0] EV_STATUS = 3'd1;
   localparam logic [EVENT_W-1:0] EV_START  = 3'd2;
   localparam logic [EVENT_W-1:0] EV_HOLD   = 3'd3;
   localparam logic [EVENT_W-1:0] EV_DOOR   = 3'd4;
   localparam logic [EVENT_W-1:0] EV_RESET  = 3'd5;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STATUS_CHAR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_CHAR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_CHAR   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DOOR_CHAR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_CHAR  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_MARK    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_MARK   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOW_ENABLE = 3'd7;

   // Register reset values
   localparam logic [BYTE_W-1:0] RST_STATUS_CHAR = 8'd63;
   localparam logic [BYTE_W-1:0] RST_START_CHAR  = 8'd126;
   localparam logic [BYTE_W-1:0] RST_HOLD_CHAR   = 8'd33;
   localparam logic [BYTE_W-1:0] RST_DOOR_CHAR   = 8'd64;
   localparam logic [BYTE_W-1:0] RST_RESET_CHAR  = 8'd24;
   localparam logic [BYTE_W-1:0] RST_LOW_MARK    = 8'd64;
   localparam logic [BYTE_W-1:0] RST_FULL_MARK   = 8'd96;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  read_byte;
      logic               read_valid;
      logic [EVENT_W-1:0] event_code;
      logic               overflow;
      logic               flow_send;
      logic               flow_is_xoff;
      logic [FILL_W-1:0]  fill_count;
   } rsp_type;

endpackage

[rtl/core/srxf_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module srxf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/serial_rx_fifo_realtime_filter_top.sv]
// Top level of the serial receive filter: realtime command match and ring buffer.
//
// Usage: each request item carries a function code and a received byte.
//   Receive: a byte matching a configured realtime character (or ampersand)
//   returns an event code and is not stored; any other byte is written into
//   the ring buffer, or dropped with overflow set when the buffer is full.
//   Read pops the oldest byte, flush empties the buffer. Every request item
//   yields exactly one response item with the fill count after the step and,
//   with flow control on, an XON/XOFF send request.
// Timing: receive, flush and empty reads answer in the cycle after acceptance.
//   A read that returns data passes the registered read port of the buffer
//   RAM and then the output register; the input is held off in between.
// Throughput: one item per cycle while responses are taken, but a read that
//   returns data holds off the next item until its response is formed.
// Stall: a response waits in the output register until rsp_ready; a new item
//   is accepted in the same cycle the waiting response leaves.
// Reset: pointers, fill and XOFF state clear, registers take their defaults,
//   no response is pending. Buffer contents are not cleared.
// Configuration: write csr_index/csr_data with csr_wr_en while idle.
module serial_rx_fifo_realtime_filter_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  srxf_pkg::req_type                  req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output srxf_pkg::rsp_type                  rsp_payload,
   input  logic                               csr_wr_en,
   input  logic [srxf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [srxf_pkg::BYTE_W-1:0]        csr_data
);

   localparam int PTR_W  = srxf_pkg::PTR_W;
   localparam int BYTE_W = srxf_pkg::BYTE_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(srxf_pkg::BUF_DEPTH - 1);

   // Configuration registers
   logic [BYTE_W-1:0] status_char_ff, start_char_ff, hold_char_ff, door_char_ff;
   logic [BYTE_W-1:0] reset_char_ff, low_mark_ff, full_mark_ff;
   logic              flow_enable_ff;

   // Buffer control state
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] fill_ff, fill_in;
   logic             xoff_ff, xoff_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             rsp_valid_ff, rsp_valid_in;
   srxf_pkg::rsp_type rsp_ff, rsp_in;

   // Datapath
   logic              accept;
   logic              ram_wr_en, ram_rd_en;
   logic [BYTE_W-1:0] ram_rd_data;
   logic [srxf_pkg::EVENT_W-1:0] event_match;
   logic [PTR_W-1:0]  fill_inc, fill_dec;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   assign req_ready = !rd_pend_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign fill_inc  = fill_ff + 1'b1;
   assign fill_dec  = fill_ff - 1'b1;

   // Match realtime characters in priority order
   always_comb begin
      if (req_payload.rx_byte == status_char_ff) begin
         event_match = srxf_pkg::EV_STATUS;
      end else if (req_payload.rx_byte == start_char_ff) begin
         event_match = srxf_pkg::EV_START;
      end else if (req_payload.rx_byte == hold_char_ff) begin
         event_match = srxf_pkg::EV_HOLD;
      end else if (req_payload.rx_byte == door_char_ff) begin
         event_match = srxf_pkg::EV_DOOR;
      end else if (req_payload.rx_byte == reset_char_ff ||
                   req_payload.rx_byte == srxf_pkg::AMP_CHAR) begin
         event_match = srxf_pkg::EV_RESET;
      end else begin
         event_match = srxf_pkg::EV_NONE;
      end
   end

   // Decode the accepted item and compute next state and response
   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      fill_in      = fill_ff;
      xoff_in      = xoff_ff;
      rd_pend_in   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      // Finish a pending read with the RAM data
      if (rd_pend_ff) begin
         rsp_in.read_byte = ram_rd_data;
         rsp_valid_in     = 1'b1;
      end

      if (accept) begin
         rsp_in.read_byte    = '0;
         rsp_in.read_valid   = 1'b0;
         rsp_in.event_code   = srxf_pkg::EV_NONE;
         rsp_in.overflow     = 1'b0;
         rsp_in.flow_send    = 1'b0;
         rsp_in.flow_is_xoff = 1'b0;
         rsp_valid_in        = 1'b1;

         unique case (req_payload.func)
            srxf_pkg::FUNC_RX: begin
               rsp_in.event_code = event_match;
               if (event_match == srxf_pkg::EV_NONE) begin
                  if (fill_ff == PTR_LAST) begin
                     rsp_in.overflow = 1'b1;
                  end else begin
                     ram_wr_en = 1'b1;
                     wr_ptr_in = ptr_next(wr_ptr_ff);
                     fill_in   = fill_inc;
                     if (flow_enable_ff && !xoff_ff &&
                         srxf_pkg::FILL_W'(fill_inc) >= full_mark_ff) begin
                        xoff_in             = 1'b1;
                        rsp_in.flow_send    = 1'b1;
                        rsp_in.flow_is_xoff = 1'b1;
                     end
                  end
               end
            end
            srxf_pkg::FUNC_READ: begin
               if (fill_ff != '0) begin
                  ram_rd_en         = 1'b1;
                  rd_pend_in        = 1'b1;
                  rsp_valid_in      = 1'b0;
                  rsp_in.read_valid = 1'b1;
                  rd_ptr_in         = ptr_next(rd_ptr_ff);
                  fill_in           = fill_dec;
                  if (flow_enable_ff && xoff_ff &&
                      srxf_pkg::FILL_W'(fill_dec) < low_mark_ff) begin
                     xoff_in          = 1'b0;
                     rsp_in.flow_send = 1'b1;
                  end
               end
            end
            srxf_pkg::FUNC_FLUSH: begin
               rd_ptr_in        = wr_ptr_ff;
               fill_in          = '0;
               xoff_in          = 1'b0;
               rsp_in.flow_send = flow_enable_ff;
            end
            default: begin
               // unused code: report fill only
            end
         endcase
         rsp_in.fill_count = srxf_pkg::FILL_W'(fill_in);
      end
   end

   // Hold control state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         fill_ff        <= '0;
         xoff_ff        <= 1'b0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         status_char_ff <= srxf_pkg::RST_STATUS_CHAR;
         start_char_ff  <= srxf_pkg::RST_START_CHAR;
         hold_char_ff   <= srxf_pkg::RST_HOLD_CHAR;
         door_char_ff   <= srxf_pkg::RST_DOOR_CHAR;
         reset_char_ff  <= srxf_pkg::RST_RESET_CHAR;
         low_mark_ff    <= srxf_pkg::RST_LOW_MARK;
         full_mark_ff   <= srxf_pkg::RST_FULL_MARK;
         flow_enable_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         fill_ff      <= fill_in;
         xoff_ff      <= xoff_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               srxf_pkg::CSR_STATUS_CHAR: status_char_ff <= csr_data;
               srxf_pkg::CSR_START_CHAR:  start_char_ff  <= csr_data;
               srxf_pkg::CSR_HOLD_CHAR:   hold_char_ff   <= csr_data;
               srxf_pkg::CSR_DOOR_CHAR:   door_char_ff   <= csr_data;
               srxf_pkg::CSR_RESET_CHAR:  reset_char_ff  <= csr_data;
               srxf_pkg::CSR_LOW_MARK:    low_mark_ff    <= csr_data;
               srxf_pkg::CSR_FULL_MARK:   full_mark_ff   <= csr_data;
               srxf_pkg::CSR_FLOW_ENABLE: flow_enable_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Hold the response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Ring buffer storage
   srxf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (srxf_pkg::BUF_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_payload.rx_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

endmodule

[rtl/core/srxf_checker.sv]
// Port-level checker for the serial receive filter, bound to the top level.
module srxf_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input srxf_pkg::rsp_type rsp_payload
);

   // A stalled response item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response item changed while stalled");

   // A response without read data carries a zero read byte
   a_empty_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.read_valid |-> rsp_payload.read_byte == '0)
      else $error("read byte nonzero without read data");

   // XOFF flag only comes with a send request
   a_xoff_send: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.flow_is_xoff |-> rsp_payload.flow_send)
      else $error("XOFF flagged without send request");

   // An overflow leaves the buffer full and raises no event
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.overflow |->
         rsp_payload.fill_count == srxf_pkg::FILL_W'(srxf_pkg::BUF_DEPTH - 1) &&
         rsp_payload.event_code == srxf_pkg::EV_NONE)
      else $error("overflow reported with buffer not full");

   // No response item right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind serial_rx_fifo_realtime_filter_top srxf_checker u_srxf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

[tb/sv/rx_filter_checker.sv]
// Response checker for the serial receive filter: predicts every response item and compares it.
`timescale 1ns / 100ps

module rx_filter_checker
   import srxf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]    csr_data,
   output int                   pending_count,
   output int                   fail_count
);

   // Predicted buffer and pointers (head takes writes, tail serves reads)
   logic [BYTE_W-1:0] ring_copy [BUF_DEPTH];
   logic [PTR_W-1:0]  head_ptr;
   logic [PTR_W-1:0]  tail_ptr;
   logic              xoff_pred;

   // Shadow of the configuration registers
   logic [BYTE_W-1:0] status_ch, start_ch, hold_ch, door_ch, reset_ch;
   logic [BYTE_W-1:0] lo_mark, hi_mark;
   logic              flow_on;

   rsp_type expected_rsps [$];
   int      mismatches = 0;
   int      rsp_seen = 0;

   function automatic logic [FILL_W-1:0] fill_level();
      logic [PTR_W-1:0] used;
      used = head_ptr - tail_ptr;
      return FILL_W'(used);
   endfunction

   // Earlier registers win over later ones; ampersand comes last
   function automatic logic [EVENT_W-1:0] match_char(logic [BYTE_W-1:0] b);
      if (b == status_ch) return EV_STATUS;
      if (b == start_ch) return EV_START;
      if (b == hold_ch) return EV_HOLD;
      if (b == door_ch) return EV_DOOR;
      if (b == reset_ch) return EV_RESET;
      if (b == AMP_CHAR) return EV_RESET;
      return EV_NONE;
   endfunction

   // Advance the predicted state by one request item and return its response
   function automatic rsp_type rx_filter_step(req_type it);
      rsp_type          r;
      logic [PTR_W-1:0] wr_next;
      r = '0;
      case (it.func)
         FUNC_RX: begin
            r.event_code = match_char(it.rx_byte);
            if (r.event_code == EV_NONE) begin
               wr_next = head_ptr + 1'b1;
               if (wr_next == tail_ptr) begin
                  r.overflow = 1'b1;
               end else begin
                  ring_copy[head_ptr] = it.rx_byte;
                  head_ptr = wr_next;
                  if (flow_on && !xoff_pred && fill_level() >= hi_mark) begin
                     xoff_pred = 1'b1;
                     r.flow_send = 1'b1;
                     r.flow_is_xoff = 1'b1;
                  end
               end
            end
         end
         FUNC_READ: begin
            if (tail_ptr != head_ptr) begin
               r.read_byte = ring_copy[tail_ptr];
               r.read_valid = 1'b1;
               tail_ptr = tail_ptr + 1'b1;
               if (flow_on && xoff_pred && fill_level() < lo_mark) begin
                  xoff_pred = 1'b0;
                  r.flow_send = 1'b1;
               end
            end
         end
         FUNC_FLUSH: begin
            tail_ptr = head_ptr;
            xoff_pred = 1'b0;
            r.flow_send = flow_on;
         end
         default: begin
         end
      endcase
      r.fill_count = fill_level();
      return r;
   endfunction

   // Count a differing field; report only the first few
   function automatic void check_field(string fname, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         if (mismatches < 10) begin
            $display("response %0d: %s expected %0d, got %0d", rsp_seen, fname, want, got);
         end
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         head_ptr = '0;
         tail_ptr = '0;
         xoff_pred = 1'b0;
         status_ch = RST_STATUS_CHAR;
         start_ch = RST_START_CHAR;
         hold_ch = RST_HOLD_CHAR;
         door_ch = RST_DOOR_CHAR;
         reset_ch = RST_RESET_CHAR;
         lo_mark = RST_LOW_MARK;
         hi_mark = RST_FULL_MARK;
         flow_on = 1'b0;
         expected_rsps.delete();
      end else begin
         // Track register writes
         if (csr_wr_en) begin
            case (csr_index)
               CSR_STATUS_CHAR: status_ch = csr_data;
               CSR_START_CHAR:  start_ch = csr_data;
               CSR_HOLD_CHAR:   hold_ch = csr_data;
               CSR_DOOR_CHAR:   door_ch = csr_data;
               CSR_RESET_CHAR:  reset_ch = csr_data;
               CSR_LOW_MARK:    lo_mark = csr_data;
               CSR_FULL_MARK:   hi_mark = csr_data;
               CSR_FLOW_ENABLE: flow_on = csr_data[0];
               default: begin
               end
            endcase
         end
         // Compare a leaving response item with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               if (mismatches < 10) begin
                  $display("response %0d arrived with nothing expected", rsp_seen);
               end
               mismatches++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("read_byte", want.read_byte, rsp_payload.read_byte);
               check_field("read_valid", 8'(want.read_valid), 8'(rsp_payload.read_valid));
               check_field("event_code", 8'(want.event_code), 8'(rsp_payload.event_code));
               check_field("overflow", 8'(want.overflow), 8'(rsp_payload.overflow));
               check_field("flow_send", 8'(want.flow_send), 8'(rsp_payload.flow_send));
               check_field("flow_is_xoff", 8'(want.flow_is_xoff),
                           8'(rsp_payload.flow_is_xoff));
               check_field("fill_count", want.fill_count, rsp_payload.fill_count);
            end
            rsp_seen++;
         end
         // Predict the response of an accepted request item
         if (req_valid && req_ready) begin
            expected_rsps.push_back(rx_filter_step(req_payload));
         end
      end
      pending_count <= expected_rsps.size();
      fail_count <= mismatches;
   end

endmodule

[tb/sv/serial_rx_fifo_realtime_filter_top_tb.sv]
// Testbench top for the serial receive filter: clock, reset, stimulus, receiver stalls, verdict.
`timescale 1ns / 100ps

module serial_rx_fifo_realtime_filter_top_tb;
   import srxf_pkg::*;

   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 60;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_payload;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]    csr_data = '0;

   int pending_count;
   int fail_count;
   int hold_off_req = 0;
   int burst_left = 0;
   bit steady = 1'b0;
   int cycle_count = 0;

   // Realtime characters currently programmed, indexed by register
   logic [BYTE_W-1:0] live_chars [5];

   serial_rx_fifo_realtime_filter_top uut (.*);

   rx_filter_checker checker_i (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver: switch between stall patterns, hold off on request
   initial begin : rsp_side
      int seen_req;
      int stall_mode;
      int mode_left;
      int held;
      int tick;
      seen_req = 0;
      stall_mode = 0;
      mode_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_off_req != seen_req) begin
            seen_req = hold_off_req;
            rsp_ready <= 1'b0;
            held = 0;
            while (held < HOLD_OFF_CYCLES) begin
               @(posedge clock);
               held++;
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 60);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 99) < 55);
            default: rsp_ready <= (tick % 4 != 3);
         endcase
      end
   end

   // Offer one item; when the old burst ends, open a new one, after a random gap unless steady
   task automatic offer(input req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (!steady) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stop offering and hold until every response item has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CSR_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
   endtask

   // Program every register while the block is idle
   task automatic set_config(input logic [7:0] st, sa, ho, dr, rs, lo, hi, input logic fl);
      wait_idle();
      put_reg(CSR_STATUS_CHAR, st);
      put_reg(CSR_START_CHAR, sa);
      put_reg(CSR_HOLD_CHAR, ho);
      put_reg(CSR_DOOR_CHAR, dr);
      put_reg(CSR_RESET_CHAR, rs);
      put_reg(CSR_LOW_MARK, lo);
      put_reg(CSR_FULL_MARK, hi);
      // upper bits are junk and must be ignored
      put_reg(CSR_FLOW_ENABLE, {7'($urandom), fl});
      csr_wr_en <= 1'b0;
      live_chars[CSR_STATUS_CHAR] = st;
      live_chars[CSR_START_CHAR] = sa;
      live_chars[CSR_HOLD_CHAR] = ho;
      live_chars[CSR_DOOR_CHAR] = dr;
      live_chars[CSR_RESET_CHAR] = rs;
   endtask

   function automatic req_type rx_item(input logic [7:0] b);
      req_type it;
      it.func = FUNC_RX;
      it.rx_byte = b;
      return it;
   endfunction

   function automatic req_type cmd_item(input logic [FUNC_W-1:0] f);
      req_type it;
      it.func = f;
      it.rx_byte = 8'($urandom);
      return it;
   endfunction

   // Byte that will be stored, never a realtime character
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom);
      while (b == AMP_CHAR || b == live_chars[0] || b == live_chars[1] ||
             b == live_chars[2] || b == live_chars[3] || b == live_chars[4]);
      return b;
   endfunction

   // Mostly random bytes, with realtime characters mixed in
   function automatic logic [7:0] any_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return live_chars[3'($urandom_range(0, 4))];
      if (r < 20) return AMP_CHAR;
      return 8'($urandom);
   endfunction

   function automatic req_type random_item(input int rx_pct, input int rd_pct);
      req_type it;
      int      r;
      r = $urandom_range(0, 99);
      it.rx_byte = any_byte();
      if (r < rx_pct) it.func = FUNC_RX;
      else if (r < rx_pct + rd_pct) it.func = FUNC_READ;
      else if ($urandom_range(0, 1) == 1) it.func = FUNC_FLUSH;
      else it.func = FUNC_NONE;
      return it;
   endfunction

   // Random items in runs that fill, drain or churn the buffer
   task automatic run_random(input int n);
      int left;
      int rx_pct;
      int rd_pct;
      left = 0;
      rx_pct = 48;
      rd_pct = 48;
      for (int k = 0; k < n; k++) begin
         if (left == 0) begin
            left = $urandom_range(5, 40);
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
               0: begin
                  rx_pct = 85;
                  rd_pct = 11;
               end
               1: begin
                  rx_pct = 11;
                  rd_pct = 85;
               end
               default: begin
                  rx_pct = 48;
                  rd_pct = 48;
               end
            endcase
            if ($urandom_range(0, 9) == 0) wait_idle();
         end
         left--;
         offer(random_item(rx_pct, rd_pct));
      end
   endtask

   task automatic fill_run(input int n);
      for (int k = 0; k < n; k++) offer(rx_item(plain_byte()));
   endtask

   task automatic drain_run(input int n);
      for (int k = 0; k < n; k++) offer(cmd_item(FUNC_READ));
   endtask

   initial begin : stimulus
      live_chars[CSR_STATUS_CHAR] = RST_STATUS_CHAR;
      live_chars[CSR_START_CHAR] = RST_START_CHAR;
      live_chars[CSR_HOLD_CHAR] = RST_HOLD_CHAR;
      live_chars[CSR_DOOR_CHAR] = RST_DOOR_CHAR;
      live_chars[CSR_RESET_CHAR] = RST_RESET_CHAR;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Default characters, empty read, unused code, flush
      offer(rx_item(RST_STATUS_CHAR));
      offer(rx_item(RST_START_CHAR));
      offer(rx_item(RST_HOLD_CHAR));
      offer(rx_item(RST_DOOR_CHAR));
      offer(rx_item(RST_RESET_CHAR));
      offer(rx_item(AMP_CHAR));
      offer(cmd_item(FUNC_READ));
      offer(rx_item(8'h00));
      offer(rx_item(8'hFF));
      offer(rx_item(8'h80));
      offer(rx_item(8'h7F));
      offer(cmd_item(FUNC_NONE));
      offer(cmd_item(FUNC_READ));
      offer(cmd_item(FUNC_READ));
      offer(cmd_item(FUNC_FLUSH));
      offer(cmd_item(FUNC_READ));

      // Long receiver hold-off while items keep coming
      hold_off_req <= hold_off_req + 1;
      fill_run(16);
      run_random(10);

      // Extreme characters, flow on; overrun the buffer and drain it
      set_config(8'h00, 8'hFF, 8'h13, 8'h11, 8'h18, 8'd10, 8'd20, 1'b1);
      offer(rx_item(8'h00));
      offer(rx_item(8'hFF));
      offer(cmd_item(FUNC_FLUSH));
      hold_off_req <= hold_off_req + 1;
      fill_run(130);
      drain_run(129);
      run_random(10);

      // Overlapping characters and zero marks
      set_config(AMP_CHAR, 8'h40, 8'h40, 8'h40, 8'h40, 8'd0, 8'd0, 1'b1);
      offer(rx_item(AMP_CHAR));
      offer(rx_item(8'h40));
      run_random(10);

      // High mark out of reach
      set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'd255, 8'd255, 1'b1);
      fill_run(10);
      run_random(10);

      // XOFF at one byte, XON on any read
      set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'd255, 8'd1, 1'b1);
      run_random(10);

      // Disable flow control while XOFF is pending, then enable it again
      set_config(RST_STATUS_CHAR, RST_START_CHAR, RST_HOLD_CHAR, RST_DOOR_CHAR,
                 RST_RESET_CHAR, 8'd3, 8'd5, 1'b1);
      offer(cmd_item(FUNC_FLUSH));
      fill_run(8);
      set_config(RST_STATUS_CHAR, RST_START_CHAR, RST_HOLD_CHAR, RST_DOOR_CHAR,
                 RST_RESET_CHAR, 8'd3, 8'd5, 1'b0);
      drain_run(6);
      set_config(RST_STATUS_CHAR, RST_START_CHAR, RST_HOLD_CHAR, RST_DOOR_CHAR,
                 RST_RESET_CHAR, 8'd3, 8'd5, 1'b1);
      drain_run(3);
      fill_run(3);
      run_random(10);

      // Fully random settings
      for (int p = 0; p < 2; p++) begin
         set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom_range(0, 130)), 8'($urandom_range(0, 130)),
                    1'($urandom_range(0, 1)));
         run_random(10);
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
